// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers shared by the RTL; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: design/vgd_pkg.sv
// ----------------------------------------------------------------------------
// vgd_pkg
// Types, constants and helpers of the codebook ADPCM group decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package vgd_pkg;

  // codebook geometry
  localparam int unsigned NUM_PREDICTORS = 16;
  localparam int unsigned PRED_W   = (NUM_PREDICTORS > 1) ? $clog2(NUM_PREDICTORS) : 1;
  localparam int unsigned TAPS     = 8;
  localparam int unsigned TAP_W    = 3;
  localparam int unsigned SLOTS    = 2 * TAPS;
  localparam int unsigned SLOT_W   = 4;

  // field widths
  localparam int unsigned OP_W       = 2;
  localparam int unsigned PRED_IN_W  = 4;
  localparam int unsigned PRED_CODES = 2 ** PRED_IN_W;
  localparam int unsigned SC_W       = 4;
  localparam int unsigned CODE_W     = 4;
  localparam int unsigned CODES_W    = TAPS * CODE_W;
  localparam int unsigned INDEX_W    = 8;
  localparam int unsigned COEF_W     = 16;
  localparam int unsigned SMP_W      = 16;

  // datapath widths
  localparam int unsigned PROD_W = COEF_W + CODE_W;
  localparam int unsigned SUM_W  = PROD_W + TAP_W + 1;
  localparam int unsigned ACC_W  = 32;

  // arithmetic constants
  localparam int unsigned RES_SHIFT = 11;
  localparam logic [SC_W-1:0] MAX_SCALE = SC_W'(12);
  localparam logic signed [ACC_W-1:0] SMP_MAX = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] SMP_MIN = -ACC_W'(32768);

  typedef enum logic [OP_W-1:0] {
    OP_DECODE = 2'd0,
    OP_COEF   = 2'd1,
    OP_HIST   = 2'd2
  } op_t;

  typedef struct packed {
    logic [OP_W-1:0]          opcode;
    logic [PRED_IN_W-1:0]     predictor;
    logic [SC_W-1:0]          scale;
    logic [CODES_W-1:0]       codes;
    logic [INDEX_W-1:0]       coef_index;
    logic signed [COEF_W-1:0] coef_value;
    logic signed [SMP_W-1:0]  hist_older;
    logic signed [SMP_W-1:0]  hist_newest;
  } in_item_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] sample0;
    logic signed [SMP_W-1:0] sample1;
    logic signed [SMP_W-1:0] sample2;
    logic signed [SMP_W-1:0] sample3;
    logic signed [SMP_W-1:0] sample4;
    logic signed [SMP_W-1:0] sample5;
    logic signed [SMP_W-1:0] sample6;
    logic signed [SMP_W-1:0] sample7;
  } out_item_t;

  // arithmetic shift by the output gain, then clamp to a PCM sample
  function automatic logic signed [SMP_W-1:0] sat16(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] sh;
    logic signed [SMP_W-1:0] res;
    sh = acc >>> RES_SHIFT;
    if (sh > SMP_MAX) begin
      res = SMP_W'(SMP_MAX);
    end else if (sh < SMP_MIN) begin
      res = SMP_W'(SMP_MIN);
    end else begin
      res = SMP_W'(sh);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// File: design/vgd_if.sv
// ----------------------------------------------------------------------------
// vgd channel interfaces
// Valid/ready channels for decoder requests and decoded sample groups.
// ----------------------------------------------------------------------------
`default_nettype none

interface vgd_in_if;
  import vgd_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface vgd_out_if;
  import vgd_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: design/vgd_ram.sv
// ----------------------------------------------------------------------------
// vgd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module vgd_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                        wr_data,
  input  wire logic                                    rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port, hold when not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: design/vadpcm_group_decoder.sv
// ----------------------------------------------------------------------------
// vadpcm_group_decoder
// Codebook ADPCM decoder producing eight PCM samples per decode beat.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one request per beat: decode a group, write one codebook
//   coefficient, or set the two history samples. Only a decode produces a
//   beat on out_ch, holding eight samples, oldest first.
//   A decode passes the codebook read, the product stage, the residual sum
//   stage, then the output register before its result shows on out_ch.
//   Throughput: one request per cycle, sustained while out_ch does not
//   stall. The history loop closes in the last stage: two 16x16 products
//   per sample, a three-input add and the clamp, written back as the next history.
//   A coefficient write lands in the codebook RAM at its accept edge, so a
//   decode in the next beat already sees it.
//   Reset empties the pipeline and clears the history to zero; codebook
//   contents stay undefined until written.
//   When out_ch stalls, the pipeline keeps taking requests until its three
//   internal stages are full; set-history requests drain past a stalled
//   output, decodes wait behind it.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module vadpcm_group_decoder (
  input  wire logic clk,
  input  wire logic rst_n,
  vgd_in_if.sink    in_ch,
  vgd_out_if.source out_ch
);
  import vgd_pkg::*;

  // handshake and pipeline control
  logic in_acc;
  logic keep_in, dec_in, coef_wr;
  logic out_free;
  logic s1_go, s1_open, s2_go, s2_open, s3_go, s3_open;

  logic v1_r, v2_r, v3_r, out_valid_r;
  logic dec1_r, dec2_r, dec3_r;

  // codebook access
  logic [PRED_W-1:0]        pred_map [PRED_CODES];
  logic [PRED_W-1:0]        rd_addr;
  logic [PRED_W-1:0]        coef_waddr;
  logic [SLOT_W-1:0]        coef_slot;
  logic                     coef_in_range;
  logic [SLOTS-1:0]         coef_we;
  logic signed [COEF_W-1:0] coef1 [SLOTS];

  // stage 1 payload
  logic [CODES_W-1:0]       codes1_r;
  logic [SC_W-1:0]          sc1_r;
  logic signed [SMP_W-1:0]  ho1_r, hn1_r;
  logic signed [CODE_W-1:0] code1 [TAPS];

  // stage 2 payload
  logic [SC_W-1:0]          sc2_r;
  logic signed [SMP_W-1:0]  ho2_r, hn2_r;
  logic signed [COEF_W-1:0] row0_2_r [TAPS];
  logic signed [COEF_W-1:0] row1_2_r [TAPS];
  logic signed [ACC_W-1:0]  conv_nxt [TAPS];

  // stage 3 payload
  logic signed [SMP_W-1:0]  ho3_r, hn3_r;
  logic signed [COEF_W-1:0] row0_3_r [TAPS];
  logic signed [COEF_W-1:0] row1_3_r [TAPS];
  logic signed [ACC_W-1:0]  conv3_r [TAPS];

  // history loop and output
  logic signed [SMP_W-1:0]  hist_older_r, hist_newest_r;
  logic signed [ACC_W-1:0]  mo [TAPS];
  logic signed [ACC_W-1:0]  mn [TAPS];
  logic signed [ACC_W-1:0]  acc [TAPS];
  logic signed [SMP_W-1:0]  smp_nxt [TAPS];
  out_item_t                out_r;

  // decode the request kind
  assign in_acc = in_ch.valid && in_ch.ready;

  always_comb begin
    keep_in = 1'b0;
    dec_in  = 1'b0;
    coef_wr = 1'b0;
    unique case (in_ch.data.opcode)
      OP_DECODE: begin
        keep_in = 1'b1;
        dec_in  = 1'b1;
      end
      OP_HIST: begin
        keep_in = 1'b1;
      end
      OP_COEF: begin
        coef_wr = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // advance stages back to front; set-history beats skip the output register
  assign out_free = !out_valid_r || out_ch.ready;
  assign s3_go    = v3_r && (!dec3_r || out_free);
  assign s3_open  = !v3_r || s3_go;
  assign s2_go    = v2_r && s3_open;
  assign s2_open  = !v2_r || s2_go;
  assign s1_go    = v1_r && s2_open;
  assign s1_open  = !v1_r || s1_go;

  assign in_ch.ready  = s1_open;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  // wrap the predictor index onto the codebook
  for (genvar g = 0; g < PRED_CODES; g++) begin : g_pmap
    localparam int unsigned PMOD = g % NUM_PREDICTORS;
    assign pred_map[g] = PRED_W'(PMOD);
  end

  assign rd_addr       = pred_map[in_ch.data.predictor];
  assign coef_slot     = in_ch.data.coef_index[SLOT_W-1:0];
  assign coef_waddr    = in_ch.data.coef_index[SLOT_W +: PRED_W];
  assign coef_in_range = 32'(in_ch.data.coef_index[INDEX_W-1:SLOT_W]) < NUM_PREDICTORS;

  // one RAM per codebook slot, all read at the predictor address
  always_comb begin
    for (int s = 0; s < SLOTS; s++) begin
      coef_we[s] = in_acc && coef_wr && coef_in_range && (coef_slot == SLOT_W'(s));
    end
  end

  for (genvar s = 0; s < SLOTS; s++) begin : g_slot
    vgd_ram #(
      .WIDTH (COEF_W),
      .DEPTH (NUM_PREDICTORS)
    ) u_ram (
      .clk     (clk),
      .wr_en   (coef_we[s]),
      .wr_addr (coef_waddr),
      .wr_data (in_ch.data.coef_value),
      .rd_en   (in_acc),
      .rd_addr (rd_addr),
      .rd_data (coef1[s])
    );
  end

  // split the code word, first code in the top bits
  for (genvar k = 0; k < TAPS; k++) begin : g_code
    assign code1[k] = codes1_r[CODES_W-1-CODE_W*k -: CODE_W];
  end

  // products of the residual convolution, summed and scaled per sample
  for (genvar i = 0; i < TAPS; i++) begin : g_smp
    logic signed [PROD_W-1:0] prod_r [i+1];
    logic signed [SUM_W-1:0]  sum;

    // coefficient pairing row1[i-1-k] with residual k
    function automatic logic signed [COEF_W-1:0] row1_of(input int k);
      return coef1[SLOT_W'(TAPS + i - 1 - k)];
    endfunction

    always_ff @(posedge clk) begin
      if (s1_go) begin
        for (int k = 0; k < i; k++) begin
          prod_r[k] <= row1_of(k) * code1[TAP_W'(k)];
        end
        prod_r[i] <= PROD_W'(code1[TAP_W'(i)]) <<< RES_SHIFT;
      end
    end

    always_comb begin
      sum = '0;
      for (int k = 0; k <= i; k++) begin
        sum = sum + SUM_W'(prod_r[k]);
      end
    end

    assign conv_nxt[i] = ACC_W'(sum) <<< sc2_r;
  end

  // history terms close the loop in the last stage
  always_comb begin
    for (int i = 0; i < TAPS; i++) begin
      mo[i]      = row0_3_r[i] * hist_older_r;
      mn[i]      = row1_3_r[i] * hist_newest_r;
      acc[i]     = mo[i] + mn[i] + conv3_r[i];
      smp_nxt[i] = sat16(acc[i]);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r          <= 1'b0;
      v2_r          <= 1'b0;
      v3_r          <= 1'b0;
      out_valid_r   <= 1'b0;
      hist_older_r  <= '0;
      hist_newest_r <= '0;
    end else begin
      if (s1_open) begin
        v1_r <= in_acc && keep_in;
      end
      if (s2_open) begin
        v2_r <= s1_go;
      end
      if (s3_open) begin
        v3_r <= s2_go;
      end
      if (s3_go && dec3_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      // update history from the group or from a set-history beat
      if (s3_go) begin
        if (dec3_r) begin
          hist_older_r  <= smp_nxt[TAPS-2];
          hist_newest_r <= smp_nxt[TAPS-1];
        end else begin
          hist_older_r  <= ho3_r;
          hist_newest_r <= hn3_r;
        end
      end
    end
  end

  // stage 1 payload: clamp the scale on entry
  always_ff @(posedge clk) begin
    if (in_acc && s1_open) begin
      dec1_r   <= dec_in;
      codes1_r <= in_ch.data.codes;
      sc1_r    <= (in_ch.data.scale > MAX_SCALE) ? MAX_SCALE : in_ch.data.scale;
      ho1_r    <= in_ch.data.hist_older;
      hn1_r    <= in_ch.data.hist_newest;
    end
  end

  // stage 2 payload
  always_ff @(posedge clk) begin
    if (s1_go) begin
      dec2_r <= dec1_r;
      sc2_r  <= sc1_r;
      ho2_r  <= ho1_r;
      hn2_r  <= hn1_r;
      for (int t = 0; t < TAPS; t++) begin
        row0_2_r[t] <= coef1[SLOT_W'(t)];
        row1_2_r[t] <= coef1[SLOT_W'(TAPS + t)];
      end
    end
  end

  // stage 3 payload
  always_ff @(posedge clk) begin
    if (s2_go) begin
      dec3_r <= dec2_r;
      ho3_r  <= ho2_r;
      hn3_r  <= hn2_r;
      for (int t = 0; t < TAPS; t++) begin
        row0_3_r[t] <= row0_2_r[t];
        row1_3_r[t] <= row1_2_r[t];
        conv3_r[t]  <= conv_nxt[t];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (s3_go && dec3_r) begin
      out_r.sample0 <= smp_nxt[0];
      out_r.sample1 <= smp_nxt[1];
      out_r.sample2 <= smp_nxt[2];
      out_r.sample3 <= smp_nxt[3];
      out_r.sample4 <= smp_nxt[4];
      out_r.sample5 <= smp_nxt[5];
      out_r.sample6 <= smp_nxt[6];
      out_r.sample7 <= smp_nxt[7];
    end
  end

  // checks
  `ASSERT_IMPL(a_no_overwrite, clk, rst_n, out_valid_r && !out_ch.ready,
               !(s3_go && dec3_r), "decode result overwrote a stalled beat")
  `ASSERT_IMPL(a_out_source, clk, rst_n, $rose(out_valid_r), $past(v3_r && dec3_r),
               "result beat without a decode in the last stage")
  `ASSERT_NEXT(a_hist_set, clk, rst_n, s3_go && !dec3_r,
               hist_older_r == $past(ho3_r) && hist_newest_r == $past(hn3_r),
               "set-history beat not applied")
  `ASSERT_NEXT(a_hist_group, clk, rst_n, s3_go && dec3_r,
               hist_newest_r == out_r.sample7 && hist_older_r == out_r.sample6,
               "history does not follow the last group")

endmodule

`default_nettype wire
